// File: sv/acsm_pkg.sv
// acsm_pkg: opcodes, action codes and shared types of the accumulator core
// no dependencies
`default_nettype none

package acsm_pkg;

   typedef logic [1:0]        action_type;
   typedef logic [3:0]        opcode_type;
   typedef logic [15:0]       half_type;
   typedef logic [7:0]        char_type;
   typedef logic signed [8:0] in_char_type;

   localparam action_type ACT_LOAD  = 2'd0;
   localparam action_type ACT_START = 2'd1;
   localparam action_type ACT_STEP  = 2'd2;

   localparam opcode_type OP_NOP  = 4'd0;
   localparam opcode_type OP_IN   = 4'd1;
   localparam opcode_type OP_OUT  = 4'd2;
   localparam opcode_type OP_SETX = 4'd3;
   localparam opcode_type OP_SUBX = 4'd4;
   localparam opcode_type OP_TRAX = 4'd5;
   localparam opcode_type OP_TRXA = 4'd6;
   localparam opcode_type OP_LDAX = 4'd7;
   localparam opcode_type OP_STAX = 4'd8;
   localparam opcode_type OP_LDA  = 4'd9;
   localparam opcode_type OP_SUBA = 4'd10;
   localparam opcode_type OP_JNZA = 4'd11;
   localparam opcode_type OP_JZA  = 4'd12;
   localparam opcode_type OP_JNZX = 4'd13;
   localparam opcode_type OP_JZX  = 4'd14;
   localparam opcode_type OP_HALT = 4'd15;

   typedef struct packed {
      logic out_valid;
      logic took_input;
      logic halt;
      logic mem_we;
      logic reads_ptr;
   } exe_flags_type;

endpackage

`default_nettype wire

// File: sv/acsm_if.sv
// acsm_req_if, acsm_rsp_if: valid/ready channels of the accumulator core
// depends on acsm_pkg
`default_nettype none

interface acsm_req_if import acsm_pkg::*; ();
   logic        valid;
   logic        ready;
   action_type  action;
   half_type    load_word;
   in_char_type in_char;

   modport source (output valid, output action, output load_word, output in_char,
                   input ready);
   modport sink (input valid, input action, input load_word, input in_char,
                 output ready);
endinterface

interface acsm_rsp_if import acsm_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     out_valid;
   char_type out_char;
   logic     took_input;
   logic     halted;
   half_type pc_now;
   half_type acc_now;
   half_type ptr_now;

   modport source (output valid, output out_valid, output out_char,
                   output took_input, output halted, output pc_now,
                   output acc_now, output ptr_now, input ready);
   modport sink (input valid, input out_valid, input out_char,
                 input took_input, input halted, input pc_now,
                 input acc_now, input ptr_now, output ready);
endinterface

`default_nettype wire

// File: sv/acsm_ram.sv
// acsm_ram: generic single-port synchronous ram with registered read data
// no dependencies
`default_nettype none

module acsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_array[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_array[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: sv/acsm_exec.sv
// acsm_exec: executes one instruction from opcode, operand and pointed word
// depends on acsm_pkg
`default_nettype none

module acsm_exec import acsm_pkg::*; #(
   parameter int ADDR_WIDTH = 16,
   parameter int WORD_WIDTH = 16
) (
   input  wire logic [WORD_WIDTH-1:0] op,
   input  wire logic [WORD_WIDTH-1:0] v,
   input  wire logic [WORD_WIDTH-1:0] pv,
   input  wire logic [ADDR_WIDTH-1:0] ip,
   input  wire logic [WORD_WIDTH-1:0] acc,
   input  wire logic [ADDR_WIDTH-1:0] ptr,
   input  wire in_char_type           in_char,
   output logic      [ADDR_WIDTH-1:0] exe_ip,
   output logic      [WORD_WIDTH-1:0] exe_acc,
   output logic      [ADDR_WIDTH-1:0] exe_ptr,
   output logic      [WORD_WIDTH-1:0] exe_wdata,
   output exe_flags_type              exe_flags
);

   logic [ADDR_WIDTH-1:0]            va;
   logic [ADDR_WIDTH-1:0]            skip;
   logic [ADDR_WIDTH+WORD_WIDTH-1:0] v_zext;
   logic [ADDR_WIDTH+WORD_WIDTH-1:0] v_sext;
   logic [ADDR_WIDTH+WORD_WIDTH-1:0] acc_zext;
   logic [ADDR_WIDTH+WORD_WIDTH-1:0] ptr_zext;
   logic [WORD_WIDTH+8:0]            char_sext;
   logic [ADDR_WIDTH-1:0]            v_addr;
   logic [ADDR_WIDTH-1:0]            v_off;
   logic [ADDR_WIDTH-1:0]            acc_addr;
   logic [WORD_WIDTH-1:0]            ptr_word;
   logic [WORD_WIDTH-1:0]            in_word;
   opcode_type                       code;

   assign va        = ip + ADDR_WIDTH'(1);
   assign skip      = ip + ADDR_WIDTH'(2);
   assign v_zext    = {{ADDR_WIDTH{1'b0}}, v};
   assign v_sext    = {{ADDR_WIDTH{v[WORD_WIDTH-1]}}, v};
   assign acc_zext  = {{ADDR_WIDTH{1'b0}}, acc};
   assign ptr_zext  = {{WORD_WIDTH{1'b0}}, ptr};
   assign char_sext = {{WORD_WIDTH{in_char[8]}}, in_char};
   assign v_addr    = v_zext[ADDR_WIDTH-1:0];
   assign v_off     = v_sext[ADDR_WIDTH-1:0];
   assign acc_addr  = acc_zext[ADDR_WIDTH-1:0];
   assign ptr_word  = ptr_zext[WORD_WIDTH-1:0];
   assign in_word   = char_sext[WORD_WIDTH-1:0];

   // words above the opcode range behave as nop
   assign code = ((op >> 4) == '0) ? op[3:0] : OP_NOP;

   always_comb begin
      exe_ip    = skip;
      exe_acc   = acc;
      exe_ptr   = ptr;
      exe_wdata = acc;
      exe_flags = '0;
      unique case (code)
         OP_NOP: begin
            exe_ip = va;
         end
         OP_IN: begin
            exe_wdata            = in_word;
            exe_flags.mem_we     = 1'b1;
            exe_flags.took_input = 1'b1;
            exe_ip               = va;
         end
         OP_OUT: begin
            exe_flags.out_valid = 1'b1;
         end
         OP_SETX: begin
            exe_ptr = v_addr;
         end
         OP_SUBX: begin
            exe_ptr = ptr - v_addr;
         end
         OP_TRAX: begin
            exe_acc = ptr_word;
            exe_ip  = va;
         end
         OP_TRXA: begin
            exe_ptr = acc_addr;
            exe_ip  = va;
         end
         OP_LDAX: begin
            exe_flags.reads_ptr = 1'b1;
            exe_acc             = pv;
            exe_ip              = va;
         end
         OP_STAX: begin
            exe_flags.mem_we = 1'b1;
            exe_ip           = va;
         end
         OP_LDA: begin
            exe_acc = v;
         end
         OP_SUBA: begin
            exe_acc = acc - v;
         end
         OP_JNZA: begin
            if (acc != '0) begin
               exe_ip = va + v_off;
            end
         end
         OP_JZA: begin
            if (acc == '0) begin
               exe_ip = va + v_off;
            end
         end
         OP_JNZX: begin
            exe_flags.reads_ptr = 1'b1;
            if (pv != '0) begin
               exe_ip = va + v_off;
            end
         end
         OP_JZX: begin
            exe_flags.reads_ptr = 1'b1;
            if (pv == '0) begin
               exe_ip = va + v_off;
            end
         end
         OP_HALT: begin
            exe_flags.halt = 1'b1;
            exe_ip         = ip;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/accumulator_self_modifying_cpu_core.sv
// accumulator_self_modifying_cpu_core: top level, sequencer and registers
// depends on acsm_pkg, acsm_if, acsm_ram, acsm_exec
//
// usage
// req_ch carries one word per item: action (load, start, step), load_word
// and in_char. rsp_ch returns exactly one word per item with the flags of
// the executed instruction and the pc, accumulator and pointer afterwards.
// program, data and self-modified code share one single-port ram of
// 2**ADDR_WIDTH words; every access goes through that one port.
// a step reads the opcode (S_OP), then the operand (S_VAL) and executes
// there; ldax, jnzx and jzx add S_PTR, reading the pointed word. load,
// start, halted steps and unused actions go through S_MISC alone. an item
// finishes only while the output register is free; its result is then
// registered as the core returns to S_IDLE to accept the next item.
// after reset the ram is swept to zero, one word a cycle, over all
// 2**ADDR_WIDTH words (65536 at the default); req_ch.ready stays low.
// a result waiting in the output register does not block acceptance; the
// core holds its finished item until rsp_ch.ready frees the register.
`default_nettype none

module accumulator_self_modifying_cpu_core import acsm_pkg::*; #(
   parameter int ADDR_WIDTH = 16,
   parameter int WORD_WIDTH = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   acsm_req_if.sink   req_ch,
   acsm_rsp_if.source rsp_ch
);

   localparam int MEM_DEPTH = 2 ** ADDR_WIDTH;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_OP    = 3'd2;
   localparam logic [2:0] S_VAL   = 3'd3;
   localparam logic [2:0] S_PTR   = 3'd4;
   localparam logic [2:0] S_MISC  = 3'd5;

   function automatic half_type addr_to_half(input logic [ADDR_WIDTH-1:0] a);
      logic [ADDR_WIDTH+15:0] wide;
      wide = {16'b0, a};
      return wide[15:0];
   endfunction

   function automatic half_type word_to_half(input logic [WORD_WIDTH-1:0] w);
      logic [WORD_WIDTH+15:0] wide;
      wide = {16'b0, w};
      return wide[15:0];
   endfunction

   function automatic logic [WORD_WIDTH-1:0] half_to_word(input half_type h);
      logic [WORD_WIDTH+15:0] wide;
      wide = {{WORD_WIDTH{1'b0}}, h};
      return wide[WORD_WIDTH-1:0];
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [ADDR_WIDTH-1:0] clr_ff, clr_in;
   logic [ADDR_WIDTH-1:0] ip_ff, ip_in;
   logic [WORD_WIDTH-1:0] acc_ff, acc_in;
   logic [ADDR_WIDTH-1:0] ptr_ff, ptr_in;
   logic [ADDR_WIDTH:0]   load_addr_ff, load_addr_in;
   logic                  halt_ff, halt_in;
   action_type            action_ff, action_in;
   half_type              load_word_ff, load_word_in;
   in_char_type           in_char_ff, in_char_in;
   logic [WORD_WIDTH-1:0] op_ff, op_in;
   logic [WORD_WIDTH-1:0] v_ff, v_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_out_valid_ff, rsp_out_valid_in;
   char_type              rsp_out_char_ff, rsp_out_char_in;
   logic                  rsp_took_ff, rsp_took_in;
   logic                  rsp_halted_ff, rsp_halted_in;
   half_type              rsp_pc_ff, rsp_pc_in;
   half_type              rsp_acc_ff, rsp_acc_in;
   half_type              rsp_ptr_ff, rsp_ptr_in;

   logic                  accept;
   logic                  out_free;
   logic                  fin;
   logic                  ram_we;
   logic                  ram_re;
   logic [ADDR_WIDTH-1:0] ram_addr;
   logic [WORD_WIDTH-1:0] ram_wdata;
   logic [WORD_WIDTH-1:0] ram_rdata;
   logic [WORD_WIDTH-1:0] exe_v;
   logic [ADDR_WIDTH-1:0] exe_ip;
   logic [WORD_WIDTH-1:0] exe_acc;
   logic [ADDR_WIDTH-1:0] exe_ptr;
   logic [WORD_WIDTH-1:0] exe_wdata;
   exe_flags_type         exe_flags;

   acsm_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // operand comes straight from the ram in S_VAL, from v_ff once ptr is read
   assign exe_v = (state_ff == S_PTR) ? v_ff : ram_rdata;

   acsm_exec #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_exec (
      .op        (op_ff),
      .v         (exe_v),
      .pv        (ram_rdata),
      .ip        (ip_ff),
      .acc       (acc_ff),
      .ptr       (ptr_ff),
      .in_char   (in_char_ff),
      .exe_ip    (exe_ip),
      .exe_acc   (exe_acc),
      .exe_ptr   (exe_ptr),
      .exe_wdata (exe_wdata),
      .exe_flags (exe_flags)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      ip_in            = ip_ff;
      acc_in           = acc_ff;
      ptr_in           = ptr_ff;
      load_addr_in     = load_addr_ff;
      halt_in          = halt_ff;
      action_in        = action_ff;
      load_word_in     = load_word_ff;
      in_char_in       = in_char_ff;
      op_in            = op_ff;
      v_in             = v_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_out_char_in  = rsp_out_char_ff;
      rsp_took_in      = rsp_took_ff;
      rsp_halted_in    = rsp_halted_ff;
      rsp_pc_in        = rsp_pc_ff;
      rsp_acc_in       = rsp_acc_ff;
      rsp_ptr_in       = rsp_ptr_ff;
      ram_we           = 1'b0;
      ram_re           = 1'b0;
      ram_addr         = ip_ff;
      ram_wdata        = '0;
      fin              = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            clr_in = clr_ff + ADDR_WIDTH'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in    = req_ch.action;
               load_word_in = req_ch.load_word;
               in_char_in   = req_ch.in_char;
               if (req_ch.action == ACT_STEP && !halt_ff) begin
                  ram_re   = 1'b1;
                  state_in = S_OP;
               end else begin
                  state_in = S_MISC;
               end
            end
         end
         S_OP: begin
            op_in    = ram_rdata;
            ram_re   = 1'b1;
            ram_addr = ip_ff + ADDR_WIDTH'(1);
            state_in = S_VAL;
         end
         S_VAL, S_PTR: begin
            if (state_ff == S_VAL) begin
               v_in = ram_rdata;
            end
            if (state_ff == S_VAL && exe_flags.reads_ptr) begin
               ram_re   = 1'b1;
               ram_addr = ptr_ff;
               state_in = S_PTR;
            end else if (out_free) begin
               fin              = 1'b1;
               ram_we           = exe_flags.mem_we;
               ram_addr         = ptr_ff;
               ram_wdata        = exe_wdata;
               ip_in            = exe_ip;
               acc_in           = exe_acc;
               ptr_in           = exe_ptr;
               halt_in          = halt_ff || exe_flags.halt;
               rsp_out_valid_in = exe_flags.out_valid;
               rsp_out_char_in  = exe_flags.out_valid ? exe_v[7:0] : '0;
               rsp_took_in      = exe_flags.took_input;
            end
         end
         S_MISC: begin
            if (out_free) begin
               fin              = 1'b1;
               rsp_out_valid_in = 1'b0;
               rsp_out_char_in  = '0;
               rsp_took_in      = 1'b0;
               case (action_ff)
                  ACT_LOAD: begin
                     if (!load_addr_ff[ADDR_WIDTH]) begin
                        ram_we       = 1'b1;
                        ram_addr     = load_addr_ff[ADDR_WIDTH-1:0];
                        ram_wdata    = half_to_word(load_word_ff);
                        load_addr_in = load_addr_ff + (ADDR_WIDTH+1)'(1);
                     end
                  end
                  ACT_START: begin
                     ptr_in  = load_addr_ff[ADDR_WIDTH-1:0];
                     acc_in  = '0;
                     ip_in   = '0;
                     halt_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_halted_in = halt_in;
         rsp_pc_in     = addr_to_half(ip_in);
         rsp_acc_in    = word_to_half(acc_in);
         rsp_ptr_in    = addr_to_half(ptr_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ip_ff        <= '0;
         acc_ff       <= '0;
         ptr_ff       <= '0;
         load_addr_ff <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ip_ff        <= ip_in;
         acc_ff       <= acc_in;
         ptr_ff       <= ptr_in;
         load_addr_ff <= load_addr_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      load_word_ff     <= load_word_in;
      in_char_ff       <= in_char_in;
      op_ff            <= op_in;
      v_ff             <= v_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_out_char_ff  <= rsp_out_char_in;
      rsp_took_ff      <= rsp_took_in;
      rsp_halted_ff    <= rsp_halted_in;
      rsp_pc_ff        <= rsp_pc_in;
      rsp_acc_ff       <= rsp_acc_in;
      rsp_ptr_ff       <= rsp_ptr_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_valid  = rsp_out_valid_ff;
   assign rsp_ch.out_char   = rsp_out_char_ff;
   assign rsp_ch.took_input = rsp_took_ff;
   assign rsp_ch.halted     = rsp_halted_ff;
   assign rsp_ch.pc_now     = rsp_pc_ff;
   assign rsp_ch.acc_now    = rsp_acc_ff;
   assign rsp_ch.ptr_now    = rsp_ptr_ff;

   a_single_port : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_re)
      else $error("ram read and write in the same cycle");

   a_halt_holds_pc : assert property (@(posedge clock) disable iff (reset)
      halt_ff && !(state_ff == S_MISC && action_ff == ACT_START) |=> $stable(ip_ff))
      else $error("pc moved while halted");

   a_load_addr_grows : assert property (@(posedge clock) disable iff (reset)
      state_ff != S_CLEAR |=> load_addr_ff >= $past(load_addr_ff))
      else $error("load address went backwards");

   a_no_rsp_in_clear : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !rsp_valid_ff && !fin)
      else $error("result produced during ram sweep");

endmodule

`default_nettype wire
